@@ src/software_timer_bank_macros.svh @@
// Assertion macros for the software timer bank.
// Included by the top level; uses the clk and rst_n of the including scope.
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

`ifndef SYNTHESIS
`define STB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STB_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define STB_ASSERT(label, prop, msg)
`define STB_ASSERT_NEVER(label, expr, msg)
`endif

`endif

@@ src/stb_pkg.sv @@
// Shared types and constants for the software timer bank.
// No dependencies.
`default_nettype none

package stb_pkg;

    localparam int OP_W   = 3;
    localparam int IDX_W  = 4;
    localparam int MS_W   = 32;
    localparam int CNT_W  = 29;
    localparam int MASK_W = 16;
    localparam int PROD_W = 64;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for any 32-bit x
    localparam logic [MS_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int              RECIP_SHIFT = 35;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_ATTACH = 3'd1;
    localparam logic [OP_W-1:0] OP_START  = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_DETACH = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EXEC,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic walk_end;
    } status_t;

endpackage

`default_nettype wire

@@ src/stb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/stb_ctrl.sv @@
// Sequencer for the software timer bank: accepts transactions, steps the datapath.
// Depends on stb_pkg.
`default_nettype none

module stb_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [stb_pkg::OP_W-1:0]   op,
    input  wire stb_pkg::status_t           status,
    output stb_pkg::cmd_t                   cmd,
    output logic                            busy,
    output logic                            done
);

    stb_pkg::state_t state_reg;
    stb_pkg::state_t state_next;
    logic            done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stb_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        stb_pkg::OP_TICK:  state_next = stb_pkg::ST_WALK;
                        stb_pkg::OP_START: state_next = stb_pkg::ST_MUL;
                        default:           state_next = stb_pkg::ST_EXEC;
                    endcase
                end
            end
            stb_pkg::ST_MUL:  state_next = stb_pkg::ST_EXEC;
            stb_pkg::ST_EXEC: state_next = stb_pkg::ST_IDLE;
            stb_pkg::ST_WALK:
            begin
                if (status.walk_end)
                begin
                    state_next = stb_pkg::ST_IDLE;
                end
            end
            default: state_next = stb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            stb_pkg::ST_IDLE: cmd.load = start;
            stb_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                cmd.finish = 1'b1;
            end
            stb_pkg::ST_WALK:
            begin
                cmd.walk   = 1'b1;
                cmd.finish = status.walk_end;
            end
            default: cmd = '0;
        endcase
    end

    assign busy = (state_reg != stb_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

@@ src/stb_datapath.sv @@
// Timer state, period conversion and tick walk for the software timer bank.
// Depends on stb_pkg and stb_ram.
`default_nettype none

module stb_datapath #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire stb_pkg::cmd_t                cmd,
    input  wire logic [stb_pkg::OP_W-1:0]     op,
    input  wire logic [stb_pkg::IDX_W-1:0]    timer_index,
    input  wire logic [stb_pkg::MS_W-1:0]     time_ms,
    input  wire logic                         repeat_mode,
    output stb_pkg::status_t                  status,
    output logic      [stb_pkg::MASK_W-1:0]   fire_mask
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PW = $clog2(NUM_TIMERS + 1);
    localparam int CW = stb_pkg::CNT_W;

    // latched transaction
    logic [stb_pkg::OP_W-1:0]   op_reg;
    logic [stb_pkg::IDX_W-1:0]  idx_reg;
    logic [stb_pkg::MS_W-1:0]   ms_reg;
    logic                       rep_in_reg;
    logic [stb_pkg::PROD_W-1:0] prod_reg;

    logic [NUM_TIMERS-1:0] att_reg, att_next;
    logic [NUM_TIMERS-1:0] rep_reg, rep_next;
    logic [NUM_TIMERS-1:0] cnt_vld_reg, cnt_vld_next;
    logic [NUM_TIMERS-1:0] rel_vld_reg, rel_vld_next;
    logic                  rd_cvld_reg;
    logic                  rd_rvld_reg;
    logic [PW-1:0]         ptr_reg;
    logic [stb_pkg::MASK_W-1:0] acc_reg, acc_next;
    logic [stb_pkg::MASK_W-1:0] fire_mask_reg;

    logic          idx_ok;
    logic [AW-1:0] op_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] proc_addr;
    logic          proc_en;
    logic [CW-1:0] cnt_rdata, rel_rdata;
    logic [CW-1:0] cnt_eff, rel_eff;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] start_val;
    logic          fire;
    logic          cnt_we, rel_we;
    logic [AW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            idx_reg    <= timer_index;
            ms_reg     <= time_ms;
            rep_in_reg <= repeat_mode;
        end
        prod_reg <= stb_pkg::PROD_W'(ms_reg) * stb_pkg::PROD_W'(stb_pkg::RECIP10);
        if (cmd.finish)
        begin
            fire_mask_reg <= cmd.walk ? acc_next : '0;
        end
    end

    assign start_val = CW'(prod_reg >> stb_pkg::RECIP_SHIFT) + CW'(1);

    assign idx_ok    = 32'(idx_reg) < NUM_TIMERS;
    assign op_addr   = AW'(idx_reg);
    assign rd_addr   = (32'(ptr_reg) < NUM_TIMERS) ? AW'(ptr_reg) : '0;
    assign proc_addr = AW'(ptr_reg - PW'(1));
    assign proc_en   = cmd.walk && (ptr_reg != '0);

    assign cnt_eff = rd_cvld_reg ? cnt_rdata : '0;
    assign rel_eff = rd_rvld_reg ? rel_rdata : '0;
    assign cnt_dec = cnt_eff - CW'(1);

    always_comb
    begin
        att_next     = att_reg;
        rep_next     = rep_reg;
        cnt_vld_next = cnt_vld_reg;
        rel_vld_next = rel_vld_reg;
        cnt_we       = 1'b0;
        rel_we       = 1'b0;
        cnt_waddr    = op_addr;
        cnt_wdata    = '0;
        fire         = 1'b0;

        if (proc_en)
        begin
            cnt_waddr = proc_addr;
            if (att_reg[proc_addr] && (cnt_eff > CW'(1)))
            begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_dec;
                if (cnt_dec == CW'(1))
                begin
                    fire = 1'b1;
                    if (rep_reg[proc_addr])
                    begin
                        cnt_wdata = rel_eff;
                    end
                    else
                    begin
                        att_next[proc_addr] = 1'b0;
                    end
                end
            end
        end
        else if (cmd.exec && idx_ok)
        begin
            case (op_reg)
                stb_pkg::OP_ATTACH:
                begin
                    att_next[op_addr] = 1'b1;
                    cnt_we            = 1'b1;
                end
                stb_pkg::OP_START:
                begin
                    cnt_we            = 1'b1;
                    rel_we            = 1'b1;
                    cnt_wdata         = start_val;
                    rep_next[op_addr] = rep_in_reg;
                end
                stb_pkg::OP_STOP:
                begin
                    cnt_we            = 1'b1;
                    rep_next[op_addr] = 1'b0;
                end
                stb_pkg::OP_DETACH: att_next[op_addr] = 1'b0;
                default: cnt_we = 1'b0;
            endcase
        end

        if (cnt_we)
        begin
            cnt_vld_next[cnt_waddr] = 1'b1;
        end
        if (rel_we)
        begin
            rel_vld_next[op_addr] = 1'b1;
        end
    end

    // only timers 0..15 are visible in the mask
    always_comb
    begin
        acc_next = acc_reg;
        for (int b = 0; b < stb_pkg::MASK_W; b++)
        begin
            if (fire && (32'(proc_addr) == b))
            begin
                acc_next[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg     <= '0;
            rep_reg     <= '0;
            cnt_vld_reg <= '0;
            rel_vld_reg <= '0;
            rd_cvld_reg <= 1'b0;
            rd_rvld_reg <= 1'b0;
            ptr_reg     <= '0;
            acc_reg     <= '0;
        end
        else
        begin
            att_reg     <= att_next;
            rep_reg     <= rep_next;
            cnt_vld_reg <= cnt_vld_next;
            rel_vld_reg <= rel_vld_next;
            rd_cvld_reg <= cnt_vld_reg[rd_addr];
            rd_rvld_reg <= rel_vld_reg[rd_addr];
            if (cmd.load)
            begin
                ptr_reg <= '0;
                acc_reg <= '0;
            end
            else if (cmd.walk)
            begin
                ptr_reg <= ptr_reg + PW'(1);
                acc_reg <= acc_next;
            end
        end
    end

    stb_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_TIMERS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (rd_addr),
        .rdata (cnt_rdata)
    );

    stb_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_TIMERS)
    ) u_rel_ram (
        .clk   (clk),
        .we    (rel_we),
        .waddr (op_addr),
        .wdata (start_val),
        .raddr (rd_addr),
        .rdata (rel_rdata)
    );

    assign status.walk_end = (32'(ptr_reg) == NUM_TIMERS);
    assign fire_mask       = fire_mask_reg;

endmodule

`default_nettype wire

@@ src/software_timer_bank.sv @@
// Bank of NUM_TIMERS software timers. Ops other than tick pass through the EXEC state,
// start through MUL then EXEC; done is registered from the finish command. Tick walks
// the timers one per cycle through the count/reload RAM read port. A new transaction
// may be accepted in the cycle done is high. Reset (rst_n, async) detaches and clears
// all timers; count and reload read as zero until written. done is a one-cycle strobe.
`default_nettype none

module software_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [stb_pkg::OP_W-1:0]      op,
    input  wire logic [stb_pkg::IDX_W-1:0]     timer_index,
    input  wire logic [stb_pkg::MS_W-1:0]      time_ms,
    input  wire logic                          repeat_mode,
    output logic                               done,
    output logic      [stb_pkg::MASK_W-1:0]    fire_mask
);

    stb_pkg::cmd_t    cmd;
    stb_pkg::status_t status;

    stb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .timer_index (timer_index),
        .time_ms     (time_ms),
        .repeat_mode (repeat_mode),
        .status      (status),
        .fire_mask   (fire_mask)
    );

`include "software_timer_bank_macros.svh"

    `STB_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction not in progress")
    `STB_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
    `STB_ASSERT_NEVER(a_done_idle, done && busy, "result strobe while busy")
    `STB_ASSERT_NEVER(a_walk_exec, cmd.walk && cmd.exec, "tick walk overlaps op execution")

endmodule

`default_nettype wire
